>>> sv/mmnorm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmnorm_pkg
// Types and constants shared by the min/max axis normaliser.
// ----------------------------------------------------------------------------
package mmnorm_pkg;

	// Fixed field geometry
	localparam int NUM_AXES   = 3;
	localparam int AXIS_IDX_W = 2;
	localparam int RAW_W      = 16;
	localparam int DIFF_W     = 17;
	localparam int NORM_W     = 17;

	localparam logic [NORM_W-1:0]       NORM_MAX  = 17'h1FFFF;
	localparam logic signed [RAW_W-1:0] MIN_RESET = 16'sh7FFF;
	localparam logic signed [RAW_W-1:0] MAX_RESET = 16'sh8000;

	// Input word: three raw axis samples, low byte first
	typedef struct packed {
		logic [7:0] x_lsb;
		logic [7:0] x_msb;
		logic [7:0] y_lsb;
		logic [7:0] y_msb;
		logic [7:0] z_lsb;
		logic [7:0] z_msb;
	} sample_t;

	// Output word: normalised position and fresh flag per axis
	typedef struct packed {
		logic [NORM_W-1:0] norm_x;
		logic [NORM_W-1:0] norm_y;
		logic [NORM_W-1:0] norm_z;
		logic              ready_x;
		logic              ready_y;
		logic              ready_z;
	} result_t;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_DIV,
		ST_STORE,
		ST_WRITE
	} state_t;

endpackage

>>> sv/min_max_axis_normalizer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_max_axis_normalizer_unit
// Running min/max tracker and per-axis range normaliser.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (sample_valid / sample_stall / sample) takes one word of
//    six raw bytes. A word is taken when valid is high and stall is low.
//  - Output channel (result_valid / result_stall / result) gives one word
//    per input word: (v-min)/(max-min) per axis with NORM_FRAC_BITS
//    fractional bits, plus a ready flag per axis.
//  - Each axis takes a load state to update min/max, then, when its range
//    is nonzero, NORM_FRAC_BITS+1 steps of the shared restoring divider and
//    a store state. An axis with an empty range skips the divider and the
//    store state.
//  - The divider is shared across axes, so one word is in work at a time;
//    sample_stall stays high from accept until the result is registered.
//  - The result sits in an output register: the next word is taken while
//    an earlier result still waits. If result_stall holds the previous
//    word when a new one is done, the sequencer waits in its write state.
//  - Reset sets each min to 32767, each max to -32768 and held norms to 0.
// ----------------------------------------------------------------------------
module min_max_axis_normalizer_unit #(
	parameter int AXIS_COUNT     = 3,
	parameter int NORM_FRAC_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  sample_valid,
	output logic                  sample_stall,
	input  mmnorm_pkg::sample_t   sample,
	output logic                  result_valid,
	input  logic                  result_stall,
	output mmnorm_pkg::result_t   result
);

	localparam int QUOT_W = NORM_FRAC_BITS + 1;
	localparam int CNT_W  = $clog2(NORM_FRAC_BITS + 1);
	localparam int EXT_W  = QUOT_W + mmnorm_pkg::NORM_W;

	mmnorm_pkg::state_t state_q, state_d;

	mmnorm_pkg::sample_t sample_q;
	logic [mmnorm_pkg::AXIS_IDX_W-1:0] axis_q;
	logic [CNT_W-1:0] cnt_q;

	logic signed [mmnorm_pkg::RAW_W-1:0] min_q [mmnorm_pkg::NUM_AXES];
	logic signed [mmnorm_pkg::RAW_W-1:0] max_q [mmnorm_pkg::NUM_AXES];
	logic [mmnorm_pkg::NORM_W-1:0]       held_norm_q [mmnorm_pkg::NUM_AXES];
	logic [mmnorm_pkg::NUM_AXES-1:0]     ready_q;

	logic [mmnorm_pkg::DIFF_W-1:0] rem_q;
	logic [mmnorm_pkg::DIFF_W-1:0] den_q;
	logic [QUOT_W-1:0]             quot_q;

	mmnorm_pkg::result_t result_q;
	logic                result_valid_q;

	// Control strobes from the sequencer
	logic accept;
	logic do_load;
	logic do_div;
	logic do_store;
	logic do_write;

	// Axis sample selection and assembly
	logic [7:0] lsb_sel;
	logic [7:0] msb_sel;
	logic signed [mmnorm_pkg::RAW_W-1:0] v;
	logic signed [mmnorm_pkg::RAW_W-1:0] new_min;
	logic signed [mmnorm_pkg::RAW_W-1:0] new_max;
	logic [mmnorm_pkg::DIFF_W-1:0] num;
	logic [mmnorm_pkg::DIFF_W-1:0] den;
	logic range_nz;
	logic last_axis;
	logic div_done;

	// Divider step
	logic [mmnorm_pkg::DIFF_W-1:0] trial;
	logic                          trial_ge;
	logic [EXT_W-1:0]              quot_ext;
	logic [mmnorm_pkg::NORM_W-1:0] quot_sat;

	always_comb begin
		case (axis_q)
			2'd0: begin
				lsb_sel = sample_q.x_lsb;
				msb_sel = sample_q.x_msb;
			end
			2'd1: begin
				lsb_sel = sample_q.y_lsb;
				msb_sel = sample_q.y_msb;
			end
			default: begin
				lsb_sel = sample_q.z_lsb;
				msb_sel = sample_q.z_msb;
			end
		endcase
	end

	assign v       = signed'({msb_sel, lsb_sel});
	assign new_min = (v < min_q[axis_q]) ? v : min_q[axis_q];
	assign new_max = (v > max_q[axis_q]) ? v : max_q[axis_q];

	// Differences are never negative and fit 16 bits; 17 keeps the sign room
	assign num = {v[mmnorm_pkg::RAW_W-1], v}
	           - {new_min[mmnorm_pkg::RAW_W-1], new_min};
	assign den = {new_max[mmnorm_pkg::RAW_W-1], new_max}
	           - {new_min[mmnorm_pkg::RAW_W-1], new_min};

	assign range_nz  = (new_max != new_min);
	assign last_axis = (axis_q == mmnorm_pkg::AXIS_IDX_W'(AXIS_COUNT - 1));
	assign div_done  = (cnt_q == CNT_W'(NORM_FRAC_BITS));

	// Restoring step: the first step gives the integer bit, no shift
	assign trial    = (cnt_q == '0) ? rem_q : {rem_q[mmnorm_pkg::DIFF_W-2:0], 1'b0};
	assign trial_ge = (trial >= den_q);

	// Saturate the quotient into the 17-bit field
	assign quot_ext = {{mmnorm_pkg::NORM_W{1'b0}}, quot_q};
	assign quot_sat = (quot_ext > EXT_W'(mmnorm_pkg::NORM_MAX)) ? mmnorm_pkg::NORM_MAX
	                : quot_ext[mmnorm_pkg::NORM_W-1:0];

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			mmnorm_pkg::ST_IDLE: begin
				if (sample_valid) state_d = mmnorm_pkg::ST_LOAD;
			end
			mmnorm_pkg::ST_LOAD: begin
				if (range_nz)       state_d = mmnorm_pkg::ST_DIV;
				else if (last_axis) state_d = mmnorm_pkg::ST_WRITE;
			end
			mmnorm_pkg::ST_DIV: begin
				if (div_done) state_d = mmnorm_pkg::ST_STORE;
			end
			mmnorm_pkg::ST_STORE: begin
				state_d = last_axis ? mmnorm_pkg::ST_WRITE : mmnorm_pkg::ST_LOAD;
			end
			mmnorm_pkg::ST_WRITE: begin
				if (!result_valid_q || !result_stall) state_d = mmnorm_pkg::ST_IDLE;
			end
			default: state_d = mmnorm_pkg::ST_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		sample_stall = 1'b1;
		do_load      = 1'b0;
		do_div       = 1'b0;
		do_store     = 1'b0;
		do_write     = 1'b0;
		case (state_q)
			mmnorm_pkg::ST_IDLE:  sample_stall = 1'b0;
			mmnorm_pkg::ST_LOAD:  do_load = 1'b1;
			mmnorm_pkg::ST_DIV:   do_div = 1'b1;
			mmnorm_pkg::ST_STORE: do_store = 1'b1;
			mmnorm_pkg::ST_WRITE: do_write = !result_valid_q || !result_stall;
			default: sample_stall = 1'b1;
		endcase
	end

	assign accept = sample_valid && !sample_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mmnorm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Input capture
	always_ff @(posedge clk) begin
		if (accept) sample_q <= sample;
	end

	// Axis index and step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (accept) begin
				axis_q <= '0;
			end else if ((do_load && !range_nz && !last_axis) || (do_store && !last_axis)) begin
				axis_q <= axis_q + 1'b1;
			end
			if (do_load) begin
				cnt_q <= '0;
			end else if (do_div) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// Running range and held norms per axis
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < mmnorm_pkg::NUM_AXES; i++) begin
				min_q[i]       <= mmnorm_pkg::MIN_RESET;
				max_q[i]       <= mmnorm_pkg::MAX_RESET;
				held_norm_q[i] <= '0;
			end
			ready_q <= '0;
		end else begin
			if (accept) ready_q <= '0;
			if (do_load) begin
				min_q[axis_q] <= new_min;
				max_q[axis_q] <= new_max;
			end
			if (do_store) begin
				held_norm_q[axis_q] <= quot_sat;
				ready_q[axis_q]     <= 1'b1;
			end
		end
	end

	// Shared divider datapath
	always_ff @(posedge clk) begin
		if (do_load) begin
			rem_q  <= num;
			den_q  <= den;
			quot_q <= '0;
		end else if (do_div) begin
			rem_q  <= trial_ge ? (trial - den_q) : trial;
			quot_q <= {quot_q[QUOT_W-2:0], trial_ge};
		end
	end

	// Output register; unused axes never move from their reset zeros
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (do_write) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_write) begin
			result_q.norm_x  <= held_norm_q[0];
			result_q.norm_y  <= held_norm_q[1];
			result_q.norm_z  <= held_norm_q[2];
			result_q.ready_x <= ready_q[0];
			result_q.ready_y <= ready_q[1];
			result_q.ready_z <= ready_q[2];
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

>>> tb/min_max_axis_normalizer_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_max_axis_normalizer_checker
// Watches both channels of the min/max normaliser. Each accepted sample word
// is run through a behavioural copy of the running min/max tracker and
// divider. The predicted result word is queued and compared field by field
// with the next accepted result word. Mismatch and outstanding counts are
// handed back to the testbench top.
// ----------------------------------------------------------------------------
module min_max_axis_normalizer_checker
	import mmnorm_pkg::*;
#(
	parameter int AXES      = 3,
	parameter int FRAC_BITS = 16
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    sample_valid,
	input  logic    sample_stall,
	input  sample_t sample,
	input  logic    result_valid,
	input  logic    result_stall,
	input  result_t result,
	output int      fail_count,
	output int      words_outstanding,
	output int      words_checked
);

	// Running extremes and last computed norm, one entry per axis
	logic signed [RAW_W-1:0] lowest_seen  [NUM_AXES];
	logic signed [RAW_W-1:0] highest_seen [NUM_AXES];
	logic [NORM_W-1:0]       last_norm    [NUM_AXES];

	result_t expected_words [$];
	int      fails;
	int      checked;

	// Update the extremes from one sample word and work out its result word
	function automatic result_t normalise_sample(input sample_t s);
		logic signed [RAW_W-1:0] axis_val [NUM_AXES];
		logic [NORM_W-1:0]       norm     [NUM_AXES];
		logic                    fresh    [NUM_AXES];
		logic [63:0]             span;
		logic [63:0]             quot;
		result_t                 r;
		axis_val[0] = {s.x_msb, s.x_lsb};
		axis_val[1] = {s.y_msb, s.y_lsb};
		axis_val[2] = {s.z_msb, s.z_lsb};
		for (int i = 0; i < NUM_AXES; i++) begin
			norm[i]  = '0;
			fresh[i] = 1'b0;
			// axes beyond the configured count stay at zero
			if (i < AXES) begin
				if (axis_val[i] < lowest_seen[i])
					lowest_seen[i] = axis_val[i];
				if (axis_val[i] > highest_seen[i])
					highest_seen[i] = axis_val[i];
				// empty range: hold the previous norm, flag stays low
				if (highest_seen[i] != lowest_seen[i]) begin
					span = 64'(int'(highest_seen[i]) - int'(lowest_seen[i]));
					quot = (64'(int'(axis_val[i]) - int'(lowest_seen[i])) << FRAC_BITS) / span;
					if (quot > 64'(NORM_MAX))
						quot = 64'(NORM_MAX);
					last_norm[i] = quot[NORM_W-1:0];
					fresh[i]     = 1'b1;
				end
				norm[i] = last_norm[i];
			end
		end
		r.norm_x  = norm[0];
		r.norm_y  = norm[1];
		r.norm_z  = norm[2];
		r.ready_x = fresh[0];
		r.ready_y = fresh[1];
		r.ready_z = fresh[2];
		return r;
	endfunction

	task automatic check_field(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			fails++;
		end
	endtask

	// Channel monitor: compare outgoing words, then queue predictions
	always @(posedge clk or negedge arst_n) begin : watch_channels
		result_t want;
		if (!arst_n) begin
			for (int i = 0; i < NUM_AXES; i++) begin
				lowest_seen[i]  = MIN_RESET;
				highest_seen[i] = MAX_RESET;
				last_norm[i]    = '0;
			end
			expected_words.delete();
			fails   = 0;
			checked = 0;
		end else begin
			if (result_valid && !result_stall) begin
				if (expected_words.size() == 0) begin
					$error("result word arrived with none expected");
					fails++;
				end else begin
					want = expected_words.pop_front();
					check_field("norm_x", want.norm_x, result.norm_x);
					check_field("norm_y", want.norm_y, result.norm_y);
					check_field("norm_z", want.norm_z, result.norm_z);
					check_field("ready_x", want.ready_x, result.ready_x);
					check_field("ready_y", want.ready_y, result.ready_y);
					check_field("ready_z", want.ready_z, result.ready_z);
					checked++;
				end
			end
			if (sample_valid && !sample_stall)
				expected_words.push_back(normalise_sample(sample));
		end
		fail_count        <= fails;
		words_outstanding <= expected_words.size();
		words_checked     <= checked;
	end

endmodule

>>> tb/min_max_axis_normalizer_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_max_axis_normalizer_unit_test
// Drives sample words into the min/max normaliser: a directed run through
// the empty-range start-up, the byte and range extremes, then random words
// whose spread on two axes widens gradually so that many range sizes are
// divided. Sender gaps and receiver stalls change over three phases; the
// checker beside the block does the prediction and comparison.
// ----------------------------------------------------------------------------
module min_max_axis_normalizer_unit_test;
	import mmnorm_pkg::*;

	localparam int AXES           = 3;
	localparam int FRAC_BITS      = 16;
	localparam int DIRECTED_WORDS = 14;
	localparam int RANDOM_WORDS   = 1700;
	localparam int DRAIN_CYCLES   = AXES * (FRAC_BITS + 3) + 18;

	logic    clk          = 1'b0;
	logic    arst_n       = 1'b0;
	logic    sample_valid = 1'b0;
	logic    sample_stall;
	sample_t sample       = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	result_t result;

	int fail_count;
	int words_outstanding;
	int words_checked;
	int gap_pct   = 0;
	int stall_pct = 0;

	// Directed words: repeat of one value keeps the range empty, then the
	// x axis walks the byte extremes while y and z stay in a narrow band
	logic [15:0] dir_x [DIRECTED_WORDS] = '{16'h0000, 16'h0000, 16'h7FFF, 16'h8000,
		16'hFFFF, 16'h00FF, 16'hFF00, 16'h5555, 16'hAAAA, 16'h80FF, 16'h7F00,
		16'h0080, 16'h0000, 16'h7FFF};
	logic [15:0] dir_y [DIRECTED_WORDS] = '{16'h0000, 16'h0000, 16'h0001, 16'h0000,
		16'h0001, 16'h0002, 16'hFFFE, 16'h0003, 16'h0003, 16'hFFFD, 16'h0004,
		16'h0000, 16'h0001, 16'h0002};
	logic [15:0] dir_z [DIRECTED_WORDS] = '{16'h0000, 16'h0000, 16'hFFFF, 16'h0000,
		16'hFFFF, 16'h0001, 16'h0000, 16'hFFFD, 16'h0003, 16'h0002, 16'hFFFC,
		16'h0000, 16'h0000, 16'h0005};
	logic [15:0] x_corners [4] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};

	always #10 clk = ~clk;

	min_max_axis_normalizer_unit #(
		.AXIS_COUNT     (AXES),
		.NORM_FRAC_BITS (FRAC_BITS)
	) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	min_max_axis_normalizer_checker #(
		.AXES      (AXES),
		.FRAC_BITS (FRAC_BITS)
	) result_checker (
		.clk               (clk),
		.arst_n            (arst_n),
		.sample_valid      (sample_valid),
		.sample_stall      (sample_stall),
		.sample            (sample),
		.result_valid      (result_valid),
		.result_stall      (result_stall),
		.result            (result),
		.fail_count        (fail_count),
		.words_outstanding (words_outstanding),
		.words_checked     (words_checked)
	);

	// Receiver back-pressure
	always @(posedge clk) begin
		result_stall <= ($urandom_range(99) < stall_pct);
	end

	function automatic sample_t pack_axes(input logic [15:0] x, input logic [15:0] y,
		input logic [15:0] z);
		sample_t s;
		s.x_lsb = x[7:0];
		s.x_msb = x[15:8];
		s.y_lsb = y[7:0];
		s.y_msb = y[15:8];
		s.z_lsb = z[7:0];
		s.z_msb = z[15:8];
		return s;
	endfunction

	// Signed value in [-2^bits, 2^bits - 1], as a raw 16-bit pattern
	function automatic logic [15:0] spread_value(input int bits);
		int v;
		v = int'($urandom_range((2 << bits) - 1)) - (1 << bits);
		return v[15:0];
	endfunction

	// Offer one word after a random gap and hold it until taken
	task automatic send_word(input sample_t w);
		while ($urandom_range(99) < gap_pct) begin
			sample_valid <= 1'b0;
			@(posedge clk);
		end
		sample_valid <= 1'b1;
		sample       <= w;
		@(posedge clk);
		while (sample_stall)
			@(posedge clk);
	endtask

	initial begin : stimulus
		int          y_bits;
		int          z_bits;
		logic [15:0] vx;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// sender idles lightly, receiver stalls heavily
		gap_pct   = 19;
		stall_pct = 67;
		for (int k = 0; k < DIRECTED_WORDS; k++)
			send_word(pack_axes(dir_x[k], dir_y[k], dir_z[k]));

		for (int k = 0; k < RANDOM_WORDS; k++) begin
			if (k == RANDOM_WORDS / 3) begin
				gap_pct   = 67;
				stall_pct = 19;
			end else if (k == 2 * RANDOM_WORDS / 3) begin
				gap_pct   = 0;
				stall_pct = 0;
			end
			// x mostly full-scale, sometimes pinned to a corner
			if ($urandom_range(9) == 0)
				vx = x_corners[$urandom_range(3)];
			else
				vx = 16'($urandom_range(16'hFFFF));
			// y spread widens linearly, z more slowly at first
			y_bits = 1 + (k * 15) / RANDOM_WORDS;
			z_bits = 1 + ((k * k / RANDOM_WORDS) * 15) / RANDOM_WORDS;
			send_word(pack_axes(vx, spread_value(y_bits), spread_value(z_bits)));
		end
		sample_valid <= 1'b0;

		do
			@(posedge clk);
		while (words_outstanding != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d directed and %0d random sample words over three idling phases,",
			DIRECTED_WORDS, RANDOM_WORDS);
		$display("with y and z ranges widening from a few counts to full scale; %0d words checked.",
			words_checked);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// Watchdog
	initial begin
		#20_000_000;
		$error("run did not finish in time, %0d words still expected", words_outstanding);
		$display("Test completed with failures");
		$finish;
	end

endmodule
